// ===== src/ssd_pkg.sv =====
// Shared widths, step counts and sequencer states for the standard deviation block.
package ssd_pkg;

   localparam int SampleWidth       = 16;
   localparam int CountWidth        = 16;
   localparam int SumWidth          = 32;
   localparam int SumSqWidth        = 47;
   localparam int StdWidth          = 24;
   localparam int MaxSamplesDefault = 65535;

   localparam int MagWidth   = 31;  // |sum| < 2^31
   localparam int AccWidth   = 64;  // signed n*sumsq - sum^2
   localparam int MulAWidth  = 32;
   localparam int MulBWidth  = 16;
   localparam int ProdWidth  = MulAWidth + MulBWidth;
   localparam int DivWidth   = 32;  // divisor n*(n-1)
   localparam int RemWidth   = 32;
   localparam int QuotWidth  = 48;  // floor(65536*v/d) < 2^48
   localparam int RootWidth  = StdWidth;
   localparam int SubWidth   = 34;
   localparam int StepWidth  = 6;

   localparam int MulLastStep  = 5;
   localparam int DivLastStep  = QuotWidth - 1;
   localparam int SqrtLastStep = RootWidth - 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_SQRT,
      ST_OUT
   } state_type;

endpackage

// ===== src/sample_standard_deviation.sv =====
// Streaming sample standard deviation (n-1 divisor) of signed Q8.8 samples, Q8.16 result.
//
// Samples arrive as req_ beats, one per cycle while req_ready is high, and are folded into a
// count, a signed sum and a sum of squares in the cycle they are taken. The beat flagged
// req_last closes the set: req_ready drops and a small sequencer computes
// floor(sqrt(65536*(n*sumsq - sum^2) / (n*(n-1)))) exactly in integers. It runs one shared
// 32x16 multiplier for n*sumsq in two halves, sum^2 in two halves and n*(n-1), then one
// shared 34-bit subtractor for a restoring divide and a digit-by-digit square root, then an
// output state that loads the rsp_ register. A one-sample set leaves the multiply state at
// its first step and skips the divide and root. The output state waits while the previous
// result has not yet been taken. Intake resumes as soon as the result sits in the output
// register, so the next set accumulates while rsp_valid waits on rsp_ready. Sets with fewer
// than two samples give 0. Once MAX_SAMPLES samples are held, further samples of the set are
// discarded and rsp_overflow is set on that set's result; a discarded beat flagged last
// still closes the set.
module sample_standard_deviation #(
   parameter int MAX_SAMPLES = ssd_pkg::MaxSamplesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ssd_pkg::SampleWidth-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ssd_pkg::StdWidth-1:0]         rsp_std_dev,
   output logic [ssd_pkg::CountWidth-1:0]       rsp_sample_count,
   output logic                                 rsp_overflow
);

   // sequencer
   ssd_pkg::state_type state_ff, state_in;
   logic [ssd_pkg::StepWidth-1:0] step_ff, step_in;

   // accumulators
   logic [ssd_pkg::CountWidth-1:0]       count_ff, count_in;
   logic signed [ssd_pkg::SumWidth-1:0]  sum_ff, sum_in;
   logic [ssd_pkg::SumSqWidth-1:0]       sumsq_ff, sumsq_in;
   logic                                 dropped_ff, dropped_in;

   // arithmetic datapath
   logic [ssd_pkg::ProdWidth-1:0]        p_ff, p_in;
   logic signed [ssd_pkg::AccWidth-1:0]  acc_ff, acc_in;
   logic [ssd_pkg::DivWidth-1:0]         d_ff, d_in;
   logic [ssd_pkg::RemWidth-1:0]         rem_ff, rem_in;
   logic [ssd_pkg::QuotWidth-1:0]        low_ff, low_in;
   logic [ssd_pkg::RootWidth-1:0]        root_ff, root_in;

   // output register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [ssd_pkg::StdWidth-1:0]         std_ff, std_in;
   logic [ssd_pkg::CountWidth-1:0]       cnt_out_ff, cnt_out_in;
   logic                                 ovf_ff, ovf_in;

   // combinational helpers
   logic                                 req_take;
   logic signed [2*ssd_pkg::SampleWidth-1:0] smp_sq;
   logic [ssd_pkg::SumWidth-1:0]         sum_abs;
   logic [ssd_pkg::MagWidth-1:0]         mag;
   logic [ssd_pkg::MulAWidth-1:0]        mul_a;
   logic [ssd_pkg::MulBWidth-1:0]        mul_b;
   logic signed [ssd_pkg::AccWidth-1:0]  addend;
   logic [ssd_pkg::AccWidth-2:0]         v;
   logic [ssd_pkg::SubWidth-1:0]         sub_a, sub_b, diff;
   logic                                 borrow;

   assign req_ready        = (state_ff == ssd_pkg::ST_IDLE);
   assign req_take         = req_valid & req_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_std_dev      = std_ff;
   assign rsp_sample_count = cnt_out_ff;
   assign rsp_overflow     = ovf_ff;

   assign smp_sq  = req_sample * req_sample;
   assign sum_abs = sum_ff[ssd_pkg::SumWidth-1] ? ssd_pkg::SumWidth'(-sum_ff)
                                                : ssd_pkg::SumWidth'(sum_ff);
   assign mag     = sum_abs[ssd_pkg::MagWidth-1:0];

   // shared multiplier, operands picked by step
   always_comb begin
      case (step_ff)
         ssd_pkg::StepWidth'(0): begin
            mul_a = ssd_pkg::MulAWidth'(sumsq_ff[23:0]);
            mul_b = count_ff;
         end
         ssd_pkg::StepWidth'(1): begin
            mul_a = ssd_pkg::MulAWidth'(sumsq_ff[ssd_pkg::SumSqWidth-1:24]);
            mul_b = count_ff;
         end
         ssd_pkg::StepWidth'(2): begin
            mul_a = ssd_pkg::MulAWidth'(mag);
            mul_b = mag[15:0];
         end
         ssd_pkg::StepWidth'(3): begin
            mul_a = ssd_pkg::MulAWidth'(mag);
            mul_b = ssd_pkg::MulBWidth'(mag[ssd_pkg::MagWidth-1:16]);
         end
         ssd_pkg::StepWidth'(4): begin
            mul_a = ssd_pkg::MulAWidth'(count_ff);
            mul_b = count_ff - 1'b1;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign p_in = ssd_pkg::ProdWidth'(mul_a) * ssd_pkg::ProdWidth'(mul_b);

   // partial product from the previous step: +n*sumsq lo/hi, -sum^2 lo/hi
   always_comb begin
      case (step_ff)
         ssd_pkg::StepWidth'(1): addend = ssd_pkg::AccWidth'(p_ff);
         ssd_pkg::StepWidth'(2): addend = ssd_pkg::AccWidth'(p_ff) <<< 24;
         ssd_pkg::StepWidth'(3): addend = -ssd_pkg::AccWidth'(p_ff);
         ssd_pkg::StepWidth'(4): addend = -(ssd_pkg::AccWidth'(p_ff) <<< 16);
         default:                addend = '0;
      endcase
   end

   // clamp at zero, as the integer form does
   assign v = acc_ff[ssd_pkg::AccWidth-1] ? '0 : acc_ff[ssd_pkg::AccWidth-2:0];

   // shared subtractor: divide trial or square-root trial
   always_comb begin
      if (state_ff == ssd_pkg::ST_SQRT) begin
         sub_a = ssd_pkg::SubWidth'({rem_ff[24:0], low_ff[ssd_pkg::QuotWidth-1 -: 2]});
         sub_b = ssd_pkg::SubWidth'({root_ff, 2'b01});
      end else begin
         sub_a = {1'b0, rem_ff, low_ff[ssd_pkg::QuotWidth-1]};
         sub_b = ssd_pkg::SubWidth'(d_ff);
      end
   end

   assign diff   = sub_a - sub_b;
   assign borrow = diff[ssd_pkg::SubWidth-1];

   // next state and datapath control
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sumsq_in     = sumsq_ff;
      dropped_in   = dropped_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;
      low_in       = low_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      std_in       = std_ff;
      cnt_out_in   = cnt_out_ff;
      ovf_in       = ovf_ff;

      case (state_ff)
         ssd_pkg::ST_IDLE: begin
            if (req_take) begin
               if (count_ff < ssd_pkg::CountWidth'(MAX_SAMPLES)) begin
                  count_in = count_ff + 1'b1;
                  sum_in   = sum_ff + ssd_pkg::SumWidth'(req_sample);
                  sumsq_in = sumsq_ff + ssd_pkg::SumSqWidth'($unsigned(smp_sq));
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ssd_pkg::ST_MUL;
                  step_in  = '0;
               end
            end
         end

         ssd_pkg::ST_MUL: begin
            acc_in  = (step_ff == '0) ? '0 : acc_ff + addend;
            step_in = step_ff + 1'b1;
            if (step_ff == '0 && count_ff < ssd_pkg::CountWidth'(2)) begin
               // fewer than two samples: result is zero
               root_in  = '0;
               state_in = ssd_pkg::ST_OUT;
            end else if (step_ff == ssd_pkg::StepWidth'(ssd_pkg::MulLastStep)) begin
               d_in     = p_ff[ssd_pkg::DivWidth-1:0];
               rem_in   = ssd_pkg::RemWidth'(v[ssd_pkg::AccWidth-2:32]);
               low_in   = {v[31:0], 16'b0};
               step_in  = '0;
               state_in = ssd_pkg::ST_DIV;
            end
         end

         ssd_pkg::ST_DIV: begin
            rem_in  = borrow ? {rem_ff[ssd_pkg::RemWidth-2:0], low_ff[ssd_pkg::QuotWidth-1]}
                             : diff[ssd_pkg::RemWidth-1:0];
            low_in  = {low_ff[ssd_pkg::QuotWidth-2:0], ~borrow};
            step_in = step_ff + 1'b1;
            if (step_ff == ssd_pkg::StepWidth'(ssd_pkg::DivLastStep)) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ssd_pkg::ST_SQRT;
            end
         end

         ssd_pkg::ST_SQRT: begin
            rem_in  = borrow ? ssd_pkg::RemWidth'(sub_a) : diff[ssd_pkg::RemWidth-1:0];
            low_in  = {low_ff[ssd_pkg::QuotWidth-3:0], 2'b00};
            root_in = {root_ff[ssd_pkg::RootWidth-2:0], ~borrow};
            step_in = step_ff + 1'b1;
            if (step_ff == ssd_pkg::StepWidth'(ssd_pkg::SqrtLastStep)) begin
               state_in = ssd_pkg::ST_OUT;
            end
         end

         ssd_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               std_in       = root_ff;
               cnt_out_in   = count_ff;
               ovf_in       = dropped_ff;
               count_in     = '0;
               sum_in       = '0;
               sumsq_in     = '0;
               dropped_in   = 1'b0;
               state_in     = ssd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ssd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssd_pkg::ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      acc_ff     <= acc_in;
      d_ff       <= d_in;
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      root_ff    <= root_in;
      std_ff     <= std_in;
      cnt_out_ff <= cnt_out_in;
      ovf_ff     <= ovf_in;
   end

endmodule

// ===== src/ssd_checker.sv =====
// Port-level assertions for the standard deviation block, bound to its top level.
module ssd_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic signed [ssd_pkg::SampleWidth-1:0] req_sample,
   input logic                                   req_last,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [ssd_pkg::StdWidth-1:0]           rsp_std_dev,
   input logic [ssd_pkg::CountWidth-1:0]         rsp_sample_count,
   input logic                                   rsp_overflow
);

   // a result beat holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_std_dev)
         && $stable(rsp_sample_count) && $stable(rsp_overflow))
      else $error("rsp beat changed while stalled");

   // closing beat starts the computation, intake stops
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("req_ready high right after a last beat");

   // every result covers at least one sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_count != '0)
      else $error("result with zero samples");

   // a single-sample set has zero deviation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_count == ssd_pkg::CountWidth'(1) |-> rsp_std_dev == '0)
      else $error("nonzero deviation for one sample");

   // no result straight out of reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind sample_standard_deviation ssd_checker u_ssd_checker (.*);

// ===== verif/sample_standard_deviation_test.sv =====
// Self-checking testbench for the streaming sample standard deviation block.
`timescale 1ns / 100ps

module sample_standard_deviation_test;

   // Run shape: the block is built with its largest set size. The watchdog limit
   // covers the divide/root tail, a full receiver stall and a full sender gap many
   // times over.
   localparam int MaxSamples  = ssd_pkg::MaxSamplesDefault;
   localparam int IdleLimit   = 2000;
   localparam int DrainCycles = 100;
   localparam int RandomBeats = 700;

   // How the values of one random set are chosen.
   typedef enum int {
      MODE_FULL,     // any 16-bit pattern
      MODE_NARROW,   // small values around zero
      MODE_EDGE,     // rails, -1, 0, +1
      MODE_CONST,    // one value repeated, zero spread
      MODE_CLUSTER   // tight spread around a random center
   } value_mode_type;

   typedef struct {
      logic [ssd_pkg::StdWidth-1:0]   std_dev;
      logic [ssd_pkg::CountWidth-1:0] sample_count;
      logic                           overflow;
   } std_result_type;

   // Running statistics of the open set, and the results still owed by the block.
   class std_dev_scoreboard;
      int unsigned     held;
      longint          total;
      longint unsigned total_sq;
      bit              dropped;
      std_result_type  owed_results[$];
      int              errors;

      // Largest r with r*r <= v, found one bit at a time from the top.
      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root, trial;
         root = 0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      // floor(sqrt(65536 * (n*sumsq - sum^2) / (n*(n-1)))), exact in 64 bits.
      function logic [ssd_pkg::StdWidth-1:0] deviation_q816();
         longint unsigned n, mag, spread, d, q, r, scaled;
         if (held < 2) return '0;
         n      = held;
         mag    = (total < 0) ? -total : total;
         spread = (n * total_sq >= mag * mag) ? n * total_sq - mag * mag : 0;
         d      = n * (n - 1);
         q      = spread / d;
         r      = spread % d;
         scaled = (q << 16) + ((r << 16) / d);
         return ssd_pkg::StdWidth'(floor_root(scaled));
      endfunction

      function void note_sample(logic signed [ssd_pkg::SampleWidth-1:0] value, logic closes);
         longint         v;
         std_result_type owed;
         v = value;
         if (held < MaxSamples) begin
            held++;
            total    += v;
            total_sq += v * v;
         end else begin
            dropped = 1'b1;
         end
         if (closes) begin
            owed.std_dev      = deviation_q816();
            owed.sample_count = 16'(held);
            owed.overflow     = dropped;
            owed_results.push_back(owed);
            held     = 0;
            total    = 0;
            total_sq = 0;
            dropped  = 1'b0;
         end
      endfunction

      function void check_result(logic [ssd_pkg::StdWidth-1:0] std_dev,
                                 logic [ssd_pkg::CountWidth-1:0] sample_count,
                                 logic overflow);
         std_result_type want;
         if (owed_results.size() == 0) begin
            $error("result beat with nothing owed: std_dev=%0d sample_count=%0d overflow=%0b",
                   std_dev, sample_count, overflow);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (std_dev !== want.std_dev) begin
            $error("std_dev mismatch: expected %0d, actual %0d", want.std_dev, std_dev);
            errors++;
         end
         if (sample_count !== want.sample_count) begin
            $error("sample_count mismatch: expected %0d, actual %0d",
                   want.sample_count, sample_count);
            errors++;
         end
         if (overflow !== want.overflow) begin
            $error("overflow mismatch: expected %0b, actual %0b", want.overflow, overflow);
            errors++;
         end
      endfunction

      function int pending();
         return owed_results.size();
      endfunction
   endclass

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic signed [ssd_pkg::SampleWidth-1:0] req_sample = '0;
   logic                                   req_last = 1'b0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [ssd_pkg::StdWidth-1:0]           rsp_std_dev;
   logic [ssd_pkg::CountWidth-1:0]         rsp_sample_count;
   logic                                   rsp_overflow;

   std_dev_scoreboard sb = new;
   bit                no_idle = 1'b0;   // both sides run without gaps while set
   int                beats_sent = 0;
   int                idle_cycles = 0;

   sample_standard_deviation #(
      .MAX_SAMPLES(MaxSamples)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample      (req_sample),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_std_dev     (rsp_std_dev),
      .rsp_sample_count(rsp_sample_count),
      .rsp_overflow    (rsp_overflow)
   );

   always #5 clock = ~clock;

   // Monitor: everything is sampled at the rising edge, before the block's own
   // updates land. Accepted sample beats feed the predictor, accepted result beats
   // are checked. The watchdog counts edges at which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_valid && req_ready) sb.note_sample(req_sample, req_last);
         if (rsp_valid && rsp_ready) sb.check_result(rsp_std_dev, rsp_sample_count, rsp_overflow);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Result side: before each result beat, hold ready low for a random number of
   // cycles, then raise it and keep it up until a beat is taken. The stall may fall
   // while the block is still accumulating, dividing or rooting.
   initial begin
      int stall;
      forever begin
         stall = no_idle ? 0 : $urandom_range(15, 0);
         repeat (stall) begin
            @(negedge clock);
            rsp_ready = 1'b0;
         end
         @(negedge clock);
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // One sample beat: optional gap with valid low, then valid held with a stable
   // payload until the block takes it. Starts and ends at a falling edge.
   task automatic send_sample(input logic signed [ssd_pkg::SampleWidth-1:0] value,
                              input logic closes);
      int gap;
      gap = no_idle ? 0 : $urandom_range(15, 0);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  = 1'b1;
      req_sample = value;
      req_last   = closes;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      beats_sent++;
   endtask

   // Sender hold-off: nothing new goes in until every owed result is out.
   task automatic wait_results_drained();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [ssd_pkg::SampleWidth-1:0] draw_sample(
         input value_mode_type mode, input logic signed [ssd_pkg::SampleWidth-1:0] center);
      logic signed [ssd_pkg::SampleWidth-1:0] v;
      case (mode)
         MODE_NARROW: begin
            v = ssd_pkg::SampleWidth'($urandom_range(64, 0));
            v = v - 16'sd32;
         end
         MODE_EDGE: begin
            case ($urandom_range(4, 0))
               0:       v = 16'sh8000;
               1:       v = 16'sh7FFF;
               2:       v = -16'sd1;
               3:       v = 16'sd1;
               default: v = 16'sd0;
            endcase
         end
         MODE_CONST: v = center;
         MODE_CLUSTER: begin
            v = ssd_pkg::SampleWidth'($urandom_range(15, 0));
            v = center + v - 16'sd8;
         end
         default: v = ssd_pkg::SampleWidth'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_set(input int len, input value_mode_type mode);
      logic signed [ssd_pkg::SampleWidth-1:0] center;
      center = ssd_pkg::SampleWidth'($urandom);
      for (int i = 0; i < len; i++) send_sample(draw_sample(mode, center), i == len - 1);
   endtask

   initial begin
      int             pick, len, random_stop;
      value_mode_type mode;

      // Reset is held from time zero and released at a falling edge.
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed: a single sample at either rail gives zero spread.
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b1);
      // Two samples, rail to rail: the widest two-point spread.
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      // All zeros, and a tiny symmetric set.
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd0, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd0, 1'b1);
      // Constant at the negative rail: large sums, zero spread.
      for (int i = 0; i < 5; i++) send_sample(16'sh8000, i == 4);
      wait_results_drained();
      // Alternating bit patterns so every sample bit toggles both ways.
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh5555, 1'b0);
      send_sample(16'shAAAA, 1'b0);
      send_sample(16'sh0001, 1'b0);
      send_sample(16'shFFFF, 1'b1);
      wait_results_drained();

      // Random sets: mostly short, some medium, some of one to three samples;
      // now and then a burst at full rate or a hold-off until results drain.
      random_stop = beats_sent + RandomBeats;
      while (beats_sent < random_stop) begin
         pick = $urandom_range(9, 0);
         if (pick < 6) len = $urandom_range(16, 1);
         else if (pick < 8) len = $urandom_range(64, 17);
         else len = $urandom_range(3, 1);
         mode    = value_mode_type'($urandom_range(4, 0));
         no_idle = ($urandom_range(5, 0) == 0);
         send_set(len, mode);
         if ($urandom_range(9, 0) == 0) wait_results_drained();
      end
      no_idle   = 1'b0;
      req_valid = 1'b0;

      // Drain, then give the block time to show any stray result.
      while (sb.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== sample_standard_deviation.f =====
src/ssd_pkg.sv
src/sample_standard_deviation.sv
src/ssd_checker.sv
verif/sample_standard_deviation_test.sv
